[rtl/core/mgfw_pkg.sv]
package mgfw_pkg;

  // Sample and accumulator widths. Full weighting sums 27 samples whose weights
  // total 64, so six guard bits keep the sum exact before the final shift.
  localparam int SAMPLE_W   = 32;
  localparam int FRAC_SHIFT = 6;
  localparam int ACC_W      = SAMPLE_W + FRAC_SHIFT;

  // Level register.
  localparam int                      FINE_LEVEL_W     = 3;
  localparam logic [FINE_LEVEL_W-1:0] FINE_LEVEL_RESET = 3'd5;
  localparam int                      LEVEL_MIN        = 2;

  // Depth of the output queue; a power of two.
  localparam int QUEUE_DEPTH = 4;

  // One fine sample word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] residual_sample;
    logic                       grid_start;
  } sample_word_t;

  // One coarse result word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] coarse_value;
    logic                       grid_last;
  } coarse_word_t;

endpackage

[rtl/core/mgfw_ram.sv]
module mgfw_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/mgfw_queue.sv]
module mgfw_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mgfw_pkg::coarse_word_t push_word,
  input  logic                   pop,
  output logic                   valid,
  output mgfw_pkg::coarse_word_t head_word
);

  import mgfw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  coarse_word_t     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Word storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  assign valid     = (count != '0);
  assign head_word = slots[rd_ptr];

endmodule

[rtl/core/multigrid_full_weighting_restrict_3d.sv]
// 3-D full-weighting restriction. Fine interior samples of a cube with side
// 2^fine_level-1 stream in x-fastest raster order, one word per cycle while
// in_ready is high; each coarse interior point leaves, also in raster order,
// as the exact 27-point (1,2,1)^3 weighted sum shifted right arithmetically
// by 6 (floor). The stencil is applied separably: a two-word shift line
// filters along x, a row RAM holds partial y sums, and a plane RAM holds
// partial z sums, each RAM updated read-modify-write at most once per sample.
// A result passes the s1, s2 and s3 stages before it is written into the
// output queue. in_ready drops only while four results are accepted but not
// yet taken, the depth of the output queue. The RAMs need no clearing:
// every partial sum is written before it is read within a grid.
// fine_level is saturated into [2, MAX_LEVEL]; a grid_start word or a
// position outside the current grid restarts at the origin, and the
// position wraps after the last sample.
module multigrid_full_weighting_restrict_3d #(
  parameter int MAX_LEVEL = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mgfw_pkg::sample_word_t              in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mgfw_pkg::coarse_word_t              out_data,
  input  logic                                cfg_write_en,
  input  logic [mgfw_pkg::FINE_LEVEL_W-1:0]   cfg_write_data
);

  import mgfw_pkg::*;

  localparam int POS_W       = MAX_LEVEL;
  localparam int CW          = MAX_LEVEL - 1;
  localparam int LVL_W       = FINE_LEVEL_W + 1;
  localparam int ROW_DEPTH   = 1 << CW;
  localparam int PLANE_DEPTH = 1 << (2 * CW);
  localparam int USED_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic          y_even;
    logic          y_ge2;
    logic          z_even;
    logic          z_ge2;
    logic          last;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
  } stencil_info_t;

  logic [FINE_LEVEL_W-1:0] fine_level;
  logic [LVL_W-1:0]        level;
  logic [POS_W:0]          side_full;
  logic [POS_W-1:0]        side;
  logic [POS_W-1:0]        side_m1;

  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;
  logic [POS_W-1:0] pos_x_next;
  logic [POS_W-1:0] pos_y_next;
  logic [POS_W-1:0] pos_z_next;
  logic [POS_W-1:0] px;
  logic [POS_W-1:0] py;
  logic [POS_W-1:0] pz;
  logic             restart;
  logic             px_end;
  logic             py_end;
  logic             pz_end;
  logic             col;
  logic             emit;
  logic             accept;
  stencil_info_t    info_in;

  logic signed [SAMPLE_W-1:0] sh1;
  logic signed [SAMPLE_W-1:0] sh2;

  logic                       v1;
  logic signed [SAMPLE_W-1:0] s1_a;
  logic signed [SAMPLE_W-1:0] s1_b;
  logic signed [SAMPLE_W-1:0] s1_c;
  stencil_info_t              s1_info;
  logic signed [ACC_W-1:0]    s1_sx;

  logic                       v2;
  logic signed [ACC_W-1:0]    s2_sx;
  stencil_info_t              s2_info;
  logic [ACC_W-1:0]           row_rd;
  logic signed [ACC_W-1:0]    row_acc;
  logic signed [ACC_W-1:0]    row_wr;
  logic signed [ACC_W-1:0]    s2_sy;

  logic                       v3;
  logic signed [ACC_W-1:0]    s3_sy;
  stencil_info_t              s3_info;
  logic [ACC_W-1:0]           plane_rd;
  logic signed [ACC_W-1:0]    plane_acc;
  logic signed [ACC_W-1:0]    plane_wr;
  logic signed [ACC_W-1:0]    total;

  logic                       push;
  coarse_word_t               push_word;
  logic                       pop;
  logic [USED_W-1:0]          used;

  // Level register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_level <= FINE_LEVEL_RESET;
    end else if (cfg_write_en) begin
      fine_level <= cfg_write_data;
    end
  end

  // Saturated level and grid side.
  always_comb begin
    level = LVL_W'(fine_level);
    if (level < LVL_W'(LEVEL_MIN)) begin
      level = LVL_W'(LEVEL_MIN);
    end
    if (level > LVL_W'(MAX_LEVEL)) begin
      level = LVL_W'(MAX_LEVEL);
    end
    side_full = ((POS_W+1)'(1) << level) - (POS_W+1)'(1);
    side      = side_full[POS_W-1:0];
    side_m1   = side - POS_W'(1);
  end

  // Position of the incoming sample and the one after it.
  always_comb begin
    restart = in_data.grid_start || (pos_x >= side) || (pos_y >= side) ||
              (pos_z >= side);
    px = restart ? '0 : pos_x;
    py = restart ? '0 : pos_y;
    pz = restart ? '0 : pos_z;

    px_end = (px == side_m1);
    py_end = (py == side_m1);
    pz_end = (pz == side_m1);

    pos_x_next = px_end ? '0 : px + POS_W'(1);
    pos_y_next = py;
    pos_z_next = pz;
    if (px_end) begin
      pos_y_next = py_end ? '0 : py + POS_W'(1);
      if (py_end) begin
        pos_z_next = pz_end ? '0 : pz + POS_W'(1);
      end
    end

    col            = !px[0] && (px[POS_W-1:1] != '0);
    info_in.y_even = !py[0];
    info_in.y_ge2  = (py[POS_W-1:1] != '0);
    info_in.z_even = !pz[0];
    info_in.z_ge2  = (pz[POS_W-1:1] != '0);
    info_in.last   = px_end && py_end && pz_end;
    info_in.cx     = px[POS_W-1:1] - CW'(1);
    info_in.cy     = py[POS_W-1:1] - CW'(1);

    emit = col && info_in.y_even && info_in.y_ge2 && info_in.z_even && info_in.z_ge2;
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  // Shift line for the x direction and the first pipeline stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      sh1     <= in_data.residual_sample;
      sh2     <= sh1;
      s1_a    <= sh2;
      s1_b    <= sh1;
      s1_c    <= in_data.residual_sample;
      s1_info <= info_in;
    end
  end

  // Stage valid bits; words that close no x triple stop here.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept && col;
      v2 <= v1;
      v3 <= v2 && s2_info.y_even && s2_info.y_ge2;
    end
  end

  // Filter along x.
  assign s1_sx = ACC_W'(s1_a) + (ACC_W'(s1_b) <<< 1) + ACC_W'(s1_c);

  always_ff @(posedge clk) begin
    s2_sx   <= s1_sx;
    s2_info <= s1_info;
  end

  // Row partial sums, one entry per coarse x.
  mgfw_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (v2),
    .wr_addr (s2_info.cx),
    .wr_data (row_wr),
    .rd_addr (s1_info.cx),
    .rd_data (row_rd)
  );

  // Filter along y: even rows close a sum and start the next one.
  always_comb begin
    row_acc = $signed(row_rd);
    s2_sy   = row_acc + s2_sx;
    if (s2_info.y_even) begin
      row_wr = s2_sx;
    end else begin
      row_wr = row_acc + (s2_sx <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    s3_sy   <= s2_sy;
    s3_info <= s2_info;
  end

  // Plane partial sums, one entry per coarse (x, y).
  mgfw_ram #(
    .WIDTH (ACC_W),
    .DEPTH (PLANE_DEPTH)
  ) u_plane_ram (
    .clk     (clk),
    .wr_en   (v3),
    .wr_addr ({s3_info.cy, s3_info.cx}),
    .wr_data (plane_wr),
    .rd_addr ({s2_info.cy, s2_info.cx}),
    .rd_data (plane_rd)
  );

  // Filter along z and the final floor shift.
  always_comb begin
    plane_acc = $signed(plane_rd);
    total     = plane_acc + s3_sy;
    if (s3_info.z_even) begin
      plane_wr = s3_sy;
    end else begin
      plane_wr = plane_acc + (s3_sy <<< 1);
    end
    push                   = v3 && s3_info.z_even && s3_info.z_ge2;
    push_word.coarse_value = total[ACC_W-1:FRAC_SHIFT];
    push_word.grid_last    = s3_info.last;
  end

  // Output queue.
  mgfw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .valid     (out_valid),
    .head_word (out_data)
  );

  assign pop = out_valid && out_ready;

  // Queue slots reserved by accepted words that will produce a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      case ({accept && emit, pop})
        2'b10:   used <= used + USED_W'(1);
        2'b01:   used <= used - USED_W'(1);
        default: used <= used;
      endcase
    end
  end

  assign in_ready = (used != USED_W'(QUEUE_DEPTH));

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mgfw_pkg::*;

  localparam int MAX_LEVEL      = 5;
  localparam int SIDE_MAX       = (1 << MAX_LEVEL) - 1;
  localparam int PLANE_WORDS    = SIDE_MAX * SIDE_MAX;
  localparam int STORE_WORDS    = 3 * PLANE_WORDS;
  localparam int SETTLE_CYCLES  = 8;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_WORDS   = 650;
  localparam int RANDOM_RESULTS = 60;

  localparam logic [SAMPLE_W-1:0] RES_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] RES_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum int {
    FILL_RANDOM,
    FILL_MAX,
    FILL_MIN,
    FILL_EXTREME,
    FILL_SMALL,
    FILL_MIXED
  } fill_style_e;

  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  sample_word_t            in_data        = '0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  coarse_word_t            out_data;
  logic                    cfg_write_en   = 1'b0;
  logic [FINE_LEVEL_W-1:0] cfg_write_data = '0;

  // Words waiting to be sent, and coarse words predicted but not yet seen.
  sample_word_t fine_words[$];
  coarse_word_t expected_coarse[$];

  // Predictor state: the three most recent fine planes, position and level.
  logic signed [SAMPLE_W-1:0] fine_planes [STORE_WORDS];
  logic [FINE_LEVEL_W-1:0]    level_reg = FINE_LEVEL_RESET;
  int unsigned                fine_x = 0;
  int unsigned                fine_y = 0;
  int unsigned                fine_z = 0;

  int   words_queued     = 0;
  int   words_accepted   = 0;
  int   coarse_predicted = 0;
  int   error_count      = 0;
  int   in_gap           = 0;
  int   out_stall        = 0;
  int   quiet_cycles     = 0;
  logic in_taken         = 1'b0;
  bit   in_burst         = 1'b0;
  bit   out_burst        = 1'b0;

  multigrid_full_weighting_restrict_3d #(
    .MAX_LEVEL(MAX_LEVEL)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The level register saturates into the supported range.
  function automatic int effective_level(logic [FINE_LEVEL_W-1:0] raw);
    int lvl;
    lvl = raw;
    if (lvl < LEVEL_MIN) lvl = LEVEL_MIN;
    if (lvl > MAX_LEVEL) lvl = MAX_LEVEL;
    return lvl;
  endfunction

  function automatic int plane_cell(input int x, input int y, input int z);
    return ((z % 3) * SIDE_MAX + y) * SIDE_MAX + x;
  endfunction

  // Exact 27-point weighted sum around a fine point, floored by the shift.
  function automatic logic signed [SAMPLE_W-1:0] full_weight(input int cx, input int cy,
                                                              input int cz);
    longint acc;
    int     taps;
    acc = 0;
    for (int dz = -1; dz <= 1; dz++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          taps = (dx != 0) + (dy != 0) + (dz != 0);
          acc += longint'(fine_planes[plane_cell(cx + dx, cy + dy, cz + dz)]) * (8 >> taps);
        end
      end
    end
    acc = acc >>> FRAC_SHIFT;
    return acc[SAMPLE_W-1:0];
  endfunction

  // Store one accepted fine word and predict the coarse word it completes, if any.
  function automatic void restrict_fine_word(sample_word_t word);
    int           side;
    coarse_word_t coarse;
    side = (1 << effective_level(level_reg)) - 1;
    if (word.grid_start || fine_x >= side || fine_y >= side || fine_z >= side) begin
      fine_x = 0;
      fine_y = 0;
      fine_z = 0;
    end
    fine_planes[plane_cell(fine_x, fine_y, fine_z)] = word.residual_sample;
    if (fine_x >= 2 && fine_y >= 2 && fine_z >= 2 &&
        fine_x % 2 == 0 && fine_y % 2 == 0 && fine_z % 2 == 0) begin
      coarse.coarse_value = full_weight(fine_x - 1, fine_y - 1, fine_z - 1);
      coarse.grid_last    = (fine_x == side - 1) && (fine_y == side - 1) &&
                            (fine_z == side - 1);
      expected_coarse.push_back(coarse);
      coarse_predicted++;
    end
    fine_x++;
    if (fine_x >= side) begin
      fine_x = 0;
      fine_y++;
      if (fine_y >= side) begin
        fine_y = 0;
        fine_z++;
        if (fine_z >= side) fine_z = 0;
      end
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] make_residual(fill_style_e style);
    case (style)
      FILL_MAX:     return RES_MAX;
      FILL_MIN:     return RES_MIN;
      FILL_EXTREME: return $urandom_range(1) ? RES_MAX : RES_MIN;
      FILL_SMALL:   return SAMPLE_W'(int'($urandom_range(200)) - 100);
      FILL_MIXED: begin
        case ($urandom_range(5))
          0:       return RES_MAX;
          1:       return RES_MIN;
          2:       return '0;
          3:       return '1;
          4:       return SAMPLE_W'(1);
          default: return $urandom();
        endcase
      end
      default:      return $urandom();
    endcase
  endfunction

  // Mostly short gaps, some long ones, none at all in a burst.
  function automatic int idle_length(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic bit count_error();
    error_count++;
    return 1'b1;
  endfunction

  task automatic check_coarse(coarse_word_t got);
    coarse_word_t want;
    if (expected_coarse.size() == 0) begin
      if (count_error())
        $display("%0t: coarse word %h arrived with none expected", $time, got);
    end else begin
      want = expected_coarse.pop_front();
      if (want.coarse_value !== got.coarse_value && count_error())
        $display("%0t: coarse_value mismatch, expected %h, got %h",
                 $time, want.coarse_value, got.coarse_value);
      if (want.grid_last !== got.grid_last && count_error())
        $display("%0t: grid_last mismatch, expected %b, got %b",
                 $time, want.grid_last, got.grid_last);
    end
  endtask

  task automatic queue_words(int count, fill_style_e style, bit first_start, int start_pct);
    sample_word_t word;
    for (int n = 0; n < count; n++) begin
      word.residual_sample = make_residual(style);
      word.grid_start      = (n == 0) ? first_start : ($urandom_range(99) < start_pct);
      fine_words.push_back(word);
    end
    words_queued += count;
  endtask

  // Returns at a falling edge once every word is in and every result is out,
  // then lets words that complete no coarse point settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (words_accepted != words_queued || expected_coarse.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge while the block is idle.
  task automatic write_level(logic [FINE_LEVEL_W-1:0] raw);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= raw;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    level_reg = raw;
  endtask

  // Sender: holds a word until it is taken, then waits out a random gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (fine_words.size() != 0) begin
        in_data  <= fine_words.pop_front();
        in_valid <= 1'b1;
        in_gap   <= idle_length(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls on the result side.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall <= idle_length(out_burst);
    end
  end

  // Monitor: predict on every accepted fine word, check every coarse word.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      restrict_fine_word(in_data);
      words_accepted++;
    end
    if (!rst && out_valid && out_ready) check_coarse(out_data);
  end

  // Watchdog: a long stretch with no word moving on either side is a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_word_t word;
    fill_style_e  style;
    int           rand_words;
    int           results_base;
    int           raw;
    int           lvl;
    int           old_level;
    int           side;
    int           count;
    int           start_pct;
    bit           force_start;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Smallest grid through an out-of-range level: the center word at the
    // negative extreme and all neighbors at the positive extreme.
    wait_idle();
    write_level(FINE_LEVEL_W'(0));
    @(posedge clk);
    for (int n = 0; n < 27; n++) begin
      word.residual_sample = (n == 13) ? RES_MIN : RES_MAX;
      word.grid_start      = (n == 0);
      fine_words.push_back(word);
    end
    words_queued += 27;

    // Largest grid, saturated from above: two rows and a few words, so the
    // position ends past the side of the smallest grid.
    wait_idle();
    write_level(FINE_LEVEL_W'(7));
    @(posedge clk);
    queue_words(2 * SIDE_MAX + 5, FILL_RANDOM, 1'b1, 0);

    // Lowering the level mid-grid leaves the position outside the new grid,
    // so the next word starts a new grid without a grid_start flag.
    wait_idle();
    write_level(FINE_LEVEL_W'(2));
    @(posedge clk);
    queue_words(27, FILL_MIXED, 1'b0, 0);

    // Random phases, mostly whole small grids with random content.
    rand_words   = 0;
    results_base = coarse_predicted;
    while (rand_words < RANDOM_WORDS || coarse_predicted - results_base < RANDOM_RESULTS) begin
      in_burst    = ($urandom_range(3) == 0);
      out_burst   = ($urandom_range(3) == 0);
      force_start = 1'b0;
      if ($urandom_range(9) < 7) begin
        // Level change: only while idle, and never growing a grid in flight.
        wait_idle();
        old_level = effective_level(level_reg);
        raw = $urandom_range(99);
        if (raw < 50)      raw = $urandom_range(0, 2);
        else if (raw < 85) raw = 3;
        else if (raw < 95) raw = 4;
        else               raw = $urandom_range(5, 7);
        write_level(FINE_LEVEL_W'(raw));
        force_start = effective_level(level_reg) > old_level &&
                      (fine_x | fine_y | fine_z) != 0;
        @(posedge clk);
      end else begin
        do @(posedge clk);
        while (fine_words.size() > 32);
      end
      lvl  = effective_level(level_reg);
      side = (1 << lvl) - 1;
      case (lvl)
        2:       count = 27 * $urandom_range(1, 3);
        3:       count = ($urandom_range(2) == 0) ? side * side * side
                                                  : $urandom_range(50, side * side * side);
        4:       count = $urandom_range(100, 500);
        default: count = $urandom_range(30, 200);
      endcase
      style     = ($urandom_range(9) < 5) ? FILL_RANDOM : fill_style_e'($urandom_range(5));
      start_pct = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 5);
      queue_words(count, style, force_start || $urandom_range(1), start_pct);
      rand_words += count;
      @(negedge clk);
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
